FILE: hdl/fast_fpe_layer_engine_defines.svh
// assertion macros used by the layer engine checker
// no dependencies; included by the checker file
`ifndef FAST_FPE_LAYER_ENGINE_DEFINES_SVH
`define FAST_FPE_LAYER_ENGINE_DEFINES_SVH

// same-cycle implication
`define FFLE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFLE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ffle_pkg.sv
// shared constants, command codes and port structs of the layer engine
// no dependencies; imported by every engine module
`timescale 1ns / 1ps

package ffle_pkg;

   localparam int WORD_MAX   = 64;
   localparam int SBOX_COUNT = 16;
   localparam int RADIX_MAX  = 256;

   localparam int DIGIT_W    = 8;
   localparam int WADDR_W    = $clog2(WORD_MAX);
   localparam int SEL_W      = 4;
   localparam int ENTRY_W    = $clog2(RADIX_MAX);
   localparam int SBOX_AW    = SEL_W + ENTRY_W;
   localparam int SBOX_DEPTH = SBOX_COUNT * RADIX_MAX;

   localparam int RADIX_W    = 9;
   localparam int LEN_W      = 7;
   localparam int BD_W       = 6;
   localparam int SBU_W      = 5;
   localparam int CMD_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam int MOD_W      = RADIX_W;
   localparam int MOD_CNT_W  = $clog2(MOD_W);

   // register reset values
   localparam logic [RADIX_W-1:0] RADIX_RST = RADIX_W'(256);
   localparam logic [LEN_W-1:0]   LEN_RST   = LEN_W'(16);
   localparam logic [BD_W-1:0]    BD1_RST   = BD_W'(1);
   localparam logic [BD_W-1:0]    BD2_RST   = BD_W'(1);
   localparam logic [SBU_W-1:0]   SBU_RST   = SBU_W'(16);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BD1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BD2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SBU   = 3'd4;

   // commands
   localparam logic [CMD_W-1:0] CMD_WR_SBOX  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WR_DIGIT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ENC      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEC      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RD_DIGIT = 3'd4;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_REJ  = 1'b1;

   typedef struct packed {
      logic [WADDR_W-1:0] rd_addr;
      logic               wr_en;
      logic [WADDR_W-1:0] wr_addr;
      logic [DIGIT_W-1:0] wr_data;
   } word_req_type;

   typedef struct packed {
      logic               wr_en;
      logic [SEL_W-1:0]   wr_sel;
      logic [ENTRY_W-1:0] wr_pos;
      logic [ENTRY_W-1:0] wr_val;
      logic               rd_inv;
      logic [SBOX_AW-1:0] rd_addr;
   } sbox_req_type;

   typedef struct packed {
      logic               go;
      logic [MOD_W-1:0]   arg;
      logic [RADIX_W-1:0] radix;
   } mod_req_type;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] rem;
   } mod_rsp_type;

endpackage

FILE: hdl/ffle_mod_unit.sv
// shared modulo unit: restoring reduction of a 9-bit value by the radix
// depends on ffle_pkg
`timescale 1ns / 1ps

module ffle_mod_unit
   import ffle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output mod_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [MOD_W-1:0]     dvd_ff, dvd_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MOD_W-1:0]     trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[MOD_W-1]};
      fits    = (trial >= req.radix);
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      if (req.go) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dvd_in  = req.arg;
         cnt_in  = '0;
      end else if (busy_ff) begin
         // one quotient bit a cycle, msb first
         rem_in = fits ? DIGIT_W'(trial - req.radix) : trial[DIGIT_W-1:0];
         dvd_in = {dvd_ff[MOD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MOD_CNT_W'(MOD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

FILE: hdl/ffle_word_store.sv
// digit word memory with per-entry valid bits; unwritten entries read as zero
// depends on ffle_pkg
`timescale 1ns / 1ps

module ffle_word_store
   import ffle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  word_req_type       req,
   output logic [DIGIT_W-1:0] rd_digit
);

   logic [DIGIT_W-1:0]  word_mem [WORD_MAX];
   logic [WORD_MAX-1:0] vld_ff, vld_in;
   logic [DIGIT_W-1:0]  data_ff;
   logic                hit_ff;

   always_comb begin
      vld_in = vld_ff;
      if (req.wr_en) begin
         vld_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         word_mem[req.wr_addr] <= req.wr_data;
      end
      data_ff <= word_mem[req.rd_addr];
      hit_ff  <= vld_ff[req.rd_addr];
   end

   assign rd_digit = hit_ff ? data_ff : '0;

endmodule

FILE: hdl/ffle_sbox_store.sv
// forward and inverse s-box pools; one write fills both tables
// depends on ffle_pkg
`timescale 1ns / 1ps

module ffle_sbox_store
   import ffle_pkg::*;
(
   input  logic               clock,
   input  sbox_req_type       req,
   output logic [DIGIT_W-1:0] rd_data
);

   logic [DIGIT_W-1:0] fwd_mem [SBOX_DEPTH];
   logic [DIGIT_W-1:0] inv_mem [SBOX_DEPTH];
   logic [DIGIT_W-1:0] fwd_q_ff;
   logic [DIGIT_W-1:0] inv_q_ff;
   logic               inv_sel_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         fwd_mem[{req.wr_sel, req.wr_pos}] <= req.wr_val;
         inv_mem[{req.wr_sel, req.wr_val}] <= req.wr_pos;
      end
      fwd_q_ff   <= fwd_mem[req.rd_addr];
      inv_q_ff   <= inv_mem[req.rd_addr];
      inv_sel_ff <= req.rd_inv;
   end

   assign rd_data = inv_sel_ff ? inv_q_ff : fwd_q_ff;

endmodule

FILE: hdl/fast_fpe_layer_engine.sv
// top level of the layer engine: command decode, sequencer and config registers
// depends on ffle_pkg, ffle_mod_unit, ffle_word_store, ffle_sbox_store
`timescale 1ns / 1ps

// Layer engine for a FAST-style format-preserving cipher. It holds a word of up
// to 64 digits and a pool of 16 s-boxes with their inverses. A command is taken
// when start is high and busy is low; exactly one result word follows, shown
// for one cycle with rsp_strobe, and it cannot be held off, so the receiver
// must take it then. Writes (s-box entry, digit) and every rejected command
// answer on the cycle after they are taken and leave busy low, so a new command
// may follow at once. A digit read holds busy high through the read-out state
// and then answers. An encrypt or decrypt layer runs the operand fetches, up to
// three passes through the shared nine-step modulo unit, two s-box lookups
// (each an issue state and a data-back state) and a shift of the word through
// the single write port of the digit memory, one digit a cycle, before the new
// digit is inserted. Config registers are plain writes with no read-back and are
// only to be written while the engine is idle.
module fast_fpe_layer_engine
   import ffle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [SEL_W-1:0]      req_sbox_sel,
   input  logic [ENTRY_W-1:0]    req_position,
   input  logic [DIGIT_W-1:0]    req_value,

   output logic                  rsp_strobe,
   output logic [DIGIT_W-1:0]    rsp_digit,
   output logic                  rsp_status,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // sequencer states
   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_RDOUT = 11'b000_0000_0010,  // digit read result
      ST_RD0   = 11'b000_0000_0100,  // operand fetches
      ST_RD1   = 11'b000_0000_1000,
      ST_RD2   = 11'b000_0001_0000,
      ST_RD3   = 11'b000_0010_0000,
      ST_MODW  = 11'b000_0100_0000,  // waiting on the modulo unit
      ST_TBL   = 11'b000_1000_0000,  // s-box read issued
      ST_TBLD  = 11'b001_0000_0000,  // s-box data back
      ST_SHIFT = 11'b010_0000_0000,  // word shift sweep
      ST_WRND  = 11'b100_0000_0000   // insert the new digit
   } state_type;

   // which layer step the modulo or table result belongs to
   typedef enum logic [3:0] {
      STEP_E_I1  = 4'd0,  // enc: (x0 + x[L-wp]) mod r, then s
      STEP_E_M   = 4'd1,  // enc: x[w] mod r
      STEP_E_I2  = 4'd2,  // enc: (s - x[w]) mod r
      STEP_E_ND  = 4'd3,  // enc: new digit from the table
      STEP_D_XL  = 4'd4,  // dec: inverse of the last digit
      STEP_D_I   = 4'd5,  // dec: (xl + x[w-1]) mod r
      STEP_D_MID = 4'd6,  // dec: second inverse lookup
      STEP_D_M   = 4'd7,  // dec: x[L-wp-1] mod r
      STEP_D_ND  = 4'd8   // dec: new digit
   } step_type;

   // config registers
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BD_W-1:0]    bd1_ff, bd1_in;
   logic [BD_W-1:0]    bd2_ff, bd2_in;
   logic [SBU_W-1:0]   sbu_ff, sbu_in;

   // sequencer control
   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // item payload
   logic               is_dec_ff, is_dec_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;
   logic [DIGIT_W-1:0] op_a_ff, op_a_in;
   logic [DIGIT_W-1:0] op_b_ff, op_b_in;
   logic [DIGIT_W-1:0] op_c_ff, op_c_in;
   logic [DIGIT_W-1:0] tmp_ff, tmp_in;
   logic [DIGIT_W-1:0] idx_ff, idx_in;
   logic [DIGIT_W-1:0] nd_ff, nd_in;
   logic [WADDR_W-1:0] sh_cnt_ff, sh_cnt_in;
   logic [DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic               rsp_status_ff, rsp_status_in;

   // effective config values and checks
   logic [RADIX_W-1:0] r_eff;
   logic [LEN_W-1:0]   len_eff;
   logic [LEN_W-1:0]   len_m1;
   logic [LEN_W-1:0]   len_wp;
   logic [LEN_W-1:0]   len_wp_m1;
   logic [SBU_W-1:0]   sbox_lim;
   logic               sel_ok;
   logic               pos_lt_r;
   logic               val_lt_r;
   logic               pos_lt_len;
   logic               branch_ok;
   logic               w_nonzero;
   logic [LEN_W-1:0]   sh_src;
   logic [LEN_W-1:0]   sh_dst;

   // links to the sub-units
   word_req_type       word_req;
   sbox_req_type       sbox_req;
   mod_req_type        mod_req;
   mod_rsp_type        mod_rsp;
   logic [DIGIT_W-1:0] digit_q;
   logic [DIGIT_W-1:0] sbox_q;

   // ---------------------------------------------------------------------
   // config write port
   // ---------------------------------------------------------------------
   always_comb begin
      radix_in = radix_ff;
      len_in   = len_ff;
      bd1_in   = bd1_ff;
      bd2_in   = bd2_ff;
      sbu_in   = sbu_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RADIX: radix_in = csr_wdata[RADIX_W-1:0];
            CSR_LEN:   len_in   = csr_wdata[LEN_W-1:0];
            CSR_BD1:   bd1_in   = csr_wdata[BD_W-1:0];
            CSR_BD2:   bd2_in   = csr_wdata[BD_W-1:0];
            CSR_SBU:   sbu_in   = csr_wdata[SBU_W-1:0];
            default: ;  // indexes past the list are ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // clamped config and range checks
   // ---------------------------------------------------------------------
   always_comb begin
      // radix clamped to [2, RADIX_MAX]
      if (radix_ff < RADIX_W'(2)) begin
         r_eff = RADIX_W'(2);
      end else if (radix_ff > RADIX_W'(RADIX_MAX)) begin
         r_eff = RADIX_W'(RADIX_MAX);
      end else begin
         r_eff = radix_ff;
      end
      // word length clamped to [2, WORD_MAX]
      if (len_ff < LEN_W'(2)) begin
         len_eff = LEN_W'(2);
      end else if (len_ff > LEN_W'(WORD_MAX)) begin
         len_eff = LEN_W'(WORD_MAX);
      end else begin
         len_eff = len_ff;
      end
      sbox_lim = (sbu_ff > SBU_W'(SBOX_COUNT)) ? SBU_W'(SBOX_COUNT) : sbu_ff;

      len_m1    = len_eff - 1'b1;
      len_wp    = len_eff - {1'b0, bd2_ff};
      len_wp_m1 = len_wp - 1'b1;

      sel_ok     = ({1'b0, req_sbox_sel} < sbox_lim);
      pos_lt_r   = ({1'b0, req_position} < r_eff);
      val_lt_r   = ({1'b0, req_value} < r_eff);
      pos_lt_len = ({1'b0, req_position} < {2'b00, len_eff});
      w_nonzero  = (bd1_ff != '0);
      branch_ok  = ({1'b0, bd1_ff} < len_eff) && (bd2_ff != '0)
                   && ({1'b0, bd2_ff} < len_eff);

      // shift sweep addresses: source for this cycle, target of last cycle's read
      if (is_dec_ff) begin
         sh_src = len_m1 - 1'b1 - {1'b0, sh_cnt_ff};
         sh_dst = len_eff - {1'b0, sh_cnt_ff};
      end else begin
         sh_src = {1'b0, sh_cnt_ff} + 1'b1;
         sh_dst = {1'b0, sh_cnt_ff} - 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_strobe_in = 1'b0;
      rsp_digit_in  = rsp_digit_ff;
      rsp_status_in = rsp_status_ff;
      is_dec_in     = is_dec_ff;
      sel_in        = sel_ff;
      op_a_in       = op_a_ff;
      op_b_in       = op_b_ff;
      op_c_in       = op_c_ff;
      tmp_in        = tmp_ff;
      idx_in        = idx_ff;
      nd_in         = nd_ff;
      sh_cnt_in     = sh_cnt_ff;

      word_req         = '0;
      sbox_req         = '0;
      sbox_req.rd_addr = {sel_ff, idx_ff};
      sbox_req.rd_inv  = is_dec_ff;
      mod_req          = '0;
      mod_req.radix    = r_eff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // reject by default: zero digit, status set, answer next cycle
               rsp_strobe_in = 1'b1;
               rsp_digit_in  = '0;
               rsp_status_in = STATUS_REJ;
               unique case (req_command)
                  CMD_WR_SBOX: begin
                     if (sel_ok && pos_lt_r && val_lt_r) begin
                        sbox_req.wr_en  = 1'b1;
                        sbox_req.wr_sel = req_sbox_sel;
                        sbox_req.wr_pos = req_position;
                        sbox_req.wr_val = req_value;
                        rsp_status_in   = STATUS_DONE;
                     end
                  end
                  CMD_WR_DIGIT: begin
                     if (pos_lt_len && val_lt_r) begin
                        word_req.wr_en   = 1'b1;
                        word_req.wr_addr = req_position[WADDR_W-1:0];
                        word_req.wr_data = req_value;
                        rsp_status_in    = STATUS_DONE;
                     end
                  end
                  CMD_RD_DIGIT: begin
                     if (pos_lt_len) begin
                        word_req.rd_addr = req_position[WADDR_W-1:0];
                        rsp_strobe_in    = 1'b0;
                        state_in         = ST_RDOUT;
                     end
                  end
                  CMD_ENC, CMD_DEC: begin
                     if (sel_ok && branch_ok) begin
                        rsp_strobe_in = 1'b0;
                        is_dec_in     = (req_command == CMD_DEC);
                        sel_in        = req_sbox_sel;
                        state_in      = ST_RD0;
                     end
                  end
                  default: ;  // unknown commands stay rejected
               endcase
            end
         end

         ST_RDOUT: begin
            rsp_strobe_in = 1'b1;
            rsp_digit_in  = digit_q;
            rsp_status_in = STATUS_DONE;
            state_in      = ST_IDLE;
         end

         // operand fetch: enc x0, x[L-wp], x[w]; dec x[L-1], x[w-1], x[L-wp-1]
         ST_RD0: begin
            word_req.rd_addr = is_dec_ff ? len_m1[WADDR_W-1:0] : '0;
            state_in         = ST_RD1;
         end

         ST_RD1: begin
            op_a_in = digit_q;
            if (is_dec_ff) begin
               word_req.rd_addr = w_nonzero ? WADDR_W'(bd1_ff - 1'b1) : '0;
            end else begin
               word_req.rd_addr = len_wp[WADDR_W-1:0];
            end
            state_in = ST_RD2;
         end

         ST_RD2: begin
            op_b_in          = digit_q;
            word_req.rd_addr = is_dec_ff ? len_wp_m1[WADDR_W-1:0] : WADDR_W'(bd1_ff);
            state_in         = ST_RD3;
         end

         ST_RD3: begin
            op_c_in = digit_q;
            if (is_dec_ff) begin
               idx_in   = op_a_ff;
               step_in  = STEP_D_XL;
               state_in = ST_TBL;
            end else begin
               mod_req.go  = 1'b1;
               mod_req.arg = {1'b0, op_a_ff} + {1'b0, op_b_ff};
               step_in     = STEP_E_I1;
               state_in    = ST_MODW;
            end
         end

         ST_MODW: begin
            if (mod_rsp.done) begin
               unique case (step_ff)
                  STEP_E_I1: begin
                     idx_in   = mod_rsp.rem;
                     state_in = ST_TBL;
                  end
                  STEP_E_M: begin
                     // s + r - (x[w] mod r) stays below 512
                     mod_req.go  = 1'b1;
                     mod_req.arg = MOD_W'({2'b00, tmp_ff} + {1'b0, r_eff}
                                          - {2'b00, mod_rsp.rem});
                     step_in     = STEP_E_I2;
                  end
                  STEP_E_I2: begin
                     idx_in   = mod_rsp.rem;
                     step_in  = STEP_E_ND;
                     state_in = ST_TBL;
                  end
                  STEP_D_I: begin
                     idx_in   = mod_rsp.rem;
                     step_in  = STEP_D_MID;
                     state_in = ST_TBL;
                  end
                  STEP_D_M: begin
                     mod_req.go  = 1'b1;
                     mod_req.arg = MOD_W'({2'b00, tmp_ff} + {1'b0, r_eff}
                                          - {2'b00, mod_rsp.rem});
                     step_in     = STEP_D_ND;
                  end
                  STEP_D_ND: begin
                     nd_in     = mod_rsp.rem;
                     sh_cnt_in = '0;
                     state_in  = ST_SHIFT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_TBL: begin
            state_in = ST_TBLD;
         end

         ST_TBLD: begin
            unique case (step_ff)
               STEP_E_I1: begin
                  tmp_in = sbox_q;
                  if (w_nonzero) begin
                     mod_req.go  = 1'b1;
                     mod_req.arg = {1'b0, op_c_ff};
                     step_in     = STEP_E_M;
                     state_in    = ST_MODW;
                  end else begin
                     // double s-box
                     idx_in   = sbox_q;
                     step_in  = STEP_E_ND;
                     state_in = ST_TBL;
                  end
               end
               STEP_E_ND: begin
                  nd_in     = sbox_q;
                  sh_cnt_in = '0;
                  state_in  = ST_SHIFT;
               end
               STEP_D_XL: begin
                  if (w_nonzero) begin
                     mod_req.go  = 1'b1;
                     mod_req.arg = {1'b0, sbox_q} + {1'b0, op_b_ff};
                     step_in     = STEP_D_I;
                     state_in    = ST_MODW;
                  end else begin
                     idx_in   = sbox_q;
                     step_in  = STEP_D_MID;
                     state_in = ST_TBL;
                  end
               end
               STEP_D_MID: begin
                  tmp_in      = sbox_q;
                  mod_req.go  = 1'b1;
                  mod_req.arg = {1'b0, op_c_ff};
                  step_in     = STEP_D_M;
                  state_in    = ST_MODW;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // one digit moved a cycle: read the source now, write it back next cycle
         ST_SHIFT: begin
            word_req.rd_addr = sh_src[WADDR_W-1:0];
            if (sh_cnt_ff != '0) begin
               word_req.wr_en   = 1'b1;
               word_req.wr_addr = sh_dst[WADDR_W-1:0];
               word_req.wr_data = digit_q;
            end
            sh_cnt_in = sh_cnt_ff + 1'b1;
            if ({1'b0, sh_cnt_ff} == len_m1) begin
               state_in = ST_WRND;
            end
         end

         ST_WRND: begin
            word_req.wr_en   = 1'b1;
            word_req.wr_addr = is_dec_ff ? '0 : len_m1[WADDR_W-1:0];
            word_req.wr_data = nd_ff;
            rsp_strobe_in    = 1'b1;
            rsp_digit_in     = nd_ff;
            rsp_status_in    = STATUS_DONE;
            state_in         = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RST;
         len_ff        <= LEN_RST;
         bd1_ff        <= BD1_RST;
         bd2_ff        <= BD2_RST;
         sbu_ff        <= SBU_RST;
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_E_I1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         radix_ff      <= radix_in;
         len_ff        <= len_in;
         bd1_ff        <= bd1_in;
         bd2_ff        <= bd2_in;
         sbu_ff        <= sbu_in;
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      is_dec_ff     <= is_dec_in;
      sel_ff        <= sel_in;
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      op_c_ff       <= op_c_in;
      tmp_ff        <= tmp_in;
      idx_ff        <= idx_in;
      nd_ff         <= nd_in;
      sh_cnt_ff     <= sh_cnt_in;
      rsp_digit_ff  <= rsp_digit_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ---------------------------------------------------------------------
   // sub-units
   // ---------------------------------------------------------------------
   ffle_mod_unit u_mod_unit (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   ffle_word_store u_word_store (
      .clock    (clock),
      .reset    (reset),
      .req      (word_req),
      .rd_digit (digit_q)
   );

   ffle_sbox_store u_sbox_store (
      .clock   (clock),
      .req     (sbox_req),
      .rd_data (sbox_q)
   );

   // outputs
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_digit  = rsp_digit_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: hdl/ffle_checker.sv
// port-level checker for the layer engine, bound to the top level
// depends on fast_fpe_layer_engine_defines.svh and fast_fpe_layer_engine
`timescale 1ns / 1ps
`include "fast_fpe_layer_engine_defines.svh"

module ffle_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_digit,
   input logic       rsp_status
);

   // a taken command either answers at once or holds the engine busy
   `FFLE_ASSERT_NEXT(a_take_then_work, clock, reset, start && !busy, busy || rsp_strobe, "command taken but engine neither busy nor answering")

   // no result word without a command taken or work in flight
   `FFLE_ASSERT_NOW(a_no_spurious_rsp, clock, reset, rsp_strobe, $past(start && !busy) || $past(busy), "result word with no command behind it")

   // finishing a long command always hands out its result
   `FFLE_ASSERT_NOW(a_done_has_rsp, clock, reset, $fell(busy), rsp_strobe, "engine went idle without a result word")

   // a rejected command returns a zero digit
   `FFLE_ASSERT_NOW(a_reject_zero, clock, reset, rsp_strobe && rsp_status, rsp_digit == 8'd0, "rejected command returned a nonzero digit")

endmodule

bind fast_fpe_layer_engine ffle_checker u_ffle_checker (.*);
